// ===== rtl/lzss_bitflag_decompressor_macros.svh =====
// Assertion helpers shared by the decoder modules.
`ifndef LZSS_BITFLAG_DECOMPRESSOR_MACROS_SVH
`define LZSS_BITFLAG_DECOMPRESSOR_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define LZBD_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define LZBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lzbd_pkg.sv =====
`timescale 1ns / 1ps
package lzbd_pkg;

  localparam int WINDOW_DEPTH_DEF = 8192;
  localparam int FLAG_BITS = 16;

  typedef enum logic [3:0] {
    PH_TYPE     = 4'd0,
    PH_KIND     = 4'd1,
    PH_INL_HI   = 4'd2,
    PH_INL_LO   = 4'd3,
    PH_LITERAL  = 4'd4,
    PH_INL_DIST = 4'd5,
    PH_FULL_LO  = 4'd6,
    PH_FULL_HI  = 4'd7,
    PH_EXTEND   = 4'd8,
    PH_DONE     = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_LIT,
    ACT_COPY,
    ACT_TERM
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_stream;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte_a;
    logic [7:0] out_byte_b;
    logic [7:0] out_byte_c;
    logic [7:0] out_byte_d;
    logic [2:0] valid_count;
    logic       last_of_run;
    logic       end_of_stream;
  } result_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic wr;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    act_t act;
    logic last_byte;
    logic grp_full;
    logic left_zero;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== rtl/lzbd_ram.sv =====
`timescale 1ns / 1ps
module lzbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lzbd_ctrl.sv =====
`timescale 1ns / 1ps
`include "lzss_bitflag_decompressor_macros.svh"
module lzbd_ctrl
  import lzbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  ctrl_sts_t  sts,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Accept, write each byte (a copy reads it first), flush groups up to four.
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          case (sts.act)
            ACT_LIT:  state_next = ST_WR;
            ACT_COPY: state_next = ST_RD;
            ACT_TERM: state_next = ST_FLUSH;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_WR;
      end
      ST_WR: begin
        cmd.wr = 1'b1;
        if (sts.grp_full || sts.last_byte) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = sts.left_zero ? ST_IDLE : ST_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `LZBD_ASSERT_NEXT(a_full_flush, (state == ST_WR) && sts.grp_full, state == ST_FLUSH, "full group not flushed")
  `LZBD_ASSERT_NEXT(a_none_idle, cmd.accept && (sts.act == ACT_NONE), state == ST_IDLE, "idle item left idle state")
  `LZBD_ASSERT_NOW(a_flush_free, !cmd.flush || sts.out_free, "flush into busy output")

endmodule

// ===== rtl/lzbd_datapath.sv =====
`timescale 1ns / 1ps
`include "lzss_bitflag_decompressor_macros.svh"
module lzbd_datapath
  import lzbd_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  ctrl_cmd_t  cmd,
  output ctrl_sts_t  sts,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  // Parser state
  logic [15:0] flag_word;
  logic [4:0]  flags_left;
  logic        flag_low_held;
  phase_t      phase;
  logic [7:0]  pending_low;
  logic [8:0]  match_length;
  logic [13:0] match_distance;

  // Copy engine state
  logic [AW-1:0] pos;
  logic [8:0]    copy_left;
  logic [13:0]   copy_dist;
  logic          lit_mode;
  logic [7:0]    lit_byte;
  logic          term;
  logic [7:0]    grp [4];
  logic [2:0]    grp_cnt;

  // Next parser state for the byte at the input
  logic [15:0] fw;
  logic [4:0]  fl;
  logic        held;
  phase_t      ph;
  logic [7:0]  pl;
  logic [8:0]  ml;
  logic [13:0] md;
  logic [8:0]  new_len;
  logic [15:0] d16;
  act_t        act;
  logic [7:0]  b;

  assign b = item.in_byte;

  always_comb begin
    fw      = flag_word;
    fl      = flags_left;
    held    = flag_low_held;
    ph      = phase;
    pl      = pending_low;
    ml      = match_length;
    md      = match_distance;
    new_len = 9'd1;
    d16     = '0;
    act     = ACT_NONE;
    if (item.start_of_stream) begin
      fw   = '0;
      fl   = '0;
      held = 1'b0;
      ph   = PH_TYPE;
    end
    if (ph != PH_DONE) begin
      if (fl == 5'd0) begin
        // Collect the two flag word bytes, low first.
        if (!held) begin
          pl   = b;
          held = 1'b1;
        end else begin
          fw   = {b, pl};
          fl   = 5'(FLAG_BITS);
          held = 1'b0;
        end
      end else begin
        case (ph)
          PH_LITERAL: begin
            act = ACT_LIT;
            ph  = PH_TYPE;
          end
          PH_INL_DIST: begin
            md      = 14'({1'b0, ~b} + 9'd1);
            new_len = ml;
            act     = ACT_COPY;
            ph      = PH_TYPE;
          end
          PH_FULL_LO: begin
            pl = b;
            ph = PH_FULL_HI;
          end
          PH_FULL_HI: begin
            d16 = {3'b111, b[7:3], pl};
            md  = 14'(~d16 + 16'd1);
            if (b[2:0] != 3'd0) begin
              ml      = 9'(b[2:0]) + 9'd2;
              new_len = ml;
              act     = ACT_COPY;
              ph      = PH_TYPE;
            end else begin
              ph = PH_EXTEND;
            end
          end
          PH_EXTEND: begin
            if (b == 8'd0) begin
              act = ACT_TERM;
              ph  = PH_DONE;
            end else if (b == 8'd1) begin
              ph = PH_TYPE;
            end else begin
              ml      = {1'b0, b} + 9'd1;
              new_len = ml;
              act     = ACT_COPY;
              ph      = PH_TYPE;
            end
          end
          default: ;
        endcase
      end
      // Consume flag bits while the parser waits on them.
      if (ph != PH_DONE) begin
        for (int i = 0; i < 4; i++) begin
          if ((fl != 5'd0) && (ph == PH_TYPE || ph == PH_KIND ||
                               ph == PH_INL_HI || ph == PH_INL_LO)) begin
            case (ph)
              PH_TYPE:   ph = fw[0] ? PH_LITERAL : PH_KIND;
              PH_KIND:   ph = fw[0] ? PH_FULL_LO : PH_INL_HI;
              PH_INL_HI: begin
                ml = fw[0] ? 9'd4 : 9'd2;
                ph = PH_INL_LO;
              end
              PH_INL_LO: begin
                ml = ml + 9'(fw[0]);
                ph = PH_INL_DIST;
              end
              default: ;
            endcase
            fw = {1'b0, fw[15:1]};
            fl = fl - 5'd1;
          end
        end
      end
    end
  end

  // Window addresses
  logic [AW:0]   pos_w;
  logic [AW:0]   dist_w;
  logic [AW:0]   src_w;
  logic [AW-1:0] pos_inc;
  logic [7:0]    rdata;
  logic [7:0]    wbyte;

  assign pos_w   = {1'b0, pos};
  assign dist_w  = (AW+1)'(copy_dist);
  assign src_w   = (pos_w >= dist_w) ? (pos_w - dist_w)
                                     : (pos_w + (AW+1)'(WINDOW_DEPTH) - dist_w);
  assign pos_inc = (pos == AW'(WINDOW_DEPTH - 1)) ? '0 : pos + AW'(1);
  assign wbyte   = lit_mode ? lit_byte : rdata;

  lzbd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (pos),
    .wdata (wbyte),
    .re    (cmd.rd),
    .raddr (src_w[AW-1:0]),
    .rdata (rdata)
  );

  // Status to the controller
  assign sts.act       = act;
  assign sts.last_byte = (copy_left == 9'd1);
  assign sts.grp_full  = (grp_cnt == 3'd3);
  assign sts.left_zero = (copy_left == 9'd0);
  assign sts.out_free  = !result_valid || !result_stall;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_word     <= '0;
      flags_left    <= '0;
      flag_low_held <= 1'b0;
      phase         <= PH_TYPE;
      pending_low   <= '0;
      match_length  <= '0;
      match_distance <= '0;
      pos           <= '0;
      copy_left     <= '0;
      term          <= 1'b0;
      grp_cnt       <= '0;
      result_valid  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        grp[i] <= '0;
      end
    end else begin
      // Take the item and update the parser.
      if (cmd.accept) begin
        flag_word      <= fw;
        flags_left     <= fl;
        flag_low_held  <= held;
        phase          <= ph;
        pending_low    <= pl;
        match_length   <= ml;
        match_distance <= md;
        if (item.start_of_stream) begin
          pos <= '0;
        end
        copy_left <= (act == ACT_LIT || act == ACT_COPY) ? new_len : 9'd0;
        term      <= (act == ACT_TERM);
      end
      // Append one decoded byte to the group and advance the window.
      if (cmd.wr) begin
        pos               <= pos_inc;
        grp[grp_cnt[1:0]] <= wbyte;
        grp_cnt           <= grp_cnt + 3'd1;
        copy_left         <= copy_left - 9'd1;
      end
      // Move the group to the output register.
      if (cmd.flush) begin
        result_valid <= 1'b1;
        grp_cnt      <= '0;
        term         <= 1'b0;
        for (int i = 0; i < 4; i++) begin
          grp[i] <= '0;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      copy_dist <= md;
      lit_mode  <= (act == ACT_LIT);
      lit_byte  <= b;
    end
    if (cmd.flush) begin
      result.out_byte_a    <= grp[0];
      result.out_byte_b    <= grp[1];
      result.out_byte_c    <= grp[2];
      result.out_byte_d    <= grp[3];
      result.valid_count   <= grp_cnt;
      result.last_of_run   <= (copy_left == 9'd0);
      result.end_of_stream <= term;
    end
  end

  `LZBD_ASSERT_NOW(a_grp_bound, grp_cnt <= 3'd4, "group count overflow")
  `LZBD_ASSERT_NOW(a_wr_left, !cmd.wr || (copy_left != 9'd0), "write with no bytes left")
  `LZBD_ASSERT_NEXT(a_flush_valid, cmd.flush, result_valid && (grp_cnt == 3'd0), "flush not taken")

endmodule

// ===== rtl/lzss_bitflag_decompressor.sv =====
`timescale 1ns / 1ps
// Kosinski stream decoder taking one compressed byte per transfer. Flag-word
// bytes, match header bytes and no-op markers give no result. A literal is
// written to the history and sent as a group of one. A match of up to 256
// bytes is copied through the history RAM: each byte is a registered read
// followed by a write, and each group of up to four bytes then moves into the
// output register, held while the output stalls. New bytes stall until the
// decoder is idle again. The 8 KiB history window needs no clearing after
// reset; start_of_stream restarts parsing but keeps the window contents.
module lzss_bitflag_decompressor
  import lzbd_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  lzbd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  lzbd_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== test/tb_lzss_bitflag_decompressor.sv =====
`timescale 1ns / 1ps
module tb_lzss_bitflag_decompressor;
  import lzbd_pkg::*;

  localparam int WIN = 8192;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  lzss_bitflag_decompressor uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #5 clk = ~clk;

  // Decoder state mirror
  logic [15:0] dec_flags;
  int          dec_left;
  bit          dec_low_held;
  phase_t      dec_phase;
  logic [7:0]  dec_low;
  int          dec_len;
  int          dec_dist;
  int          dec_pos;
  logic [7:0]  dec_hist [WIN];
  logic [7:0]  run_bytes [$];

  item_t   stim_q [$];
  result_t decoded_q [$];
  int sender_idle_pct = 11;
  int receiver_idle_pct = 55;
  int errors = 0;
  int watchdog = 0;

  // Stream generator state: how many bytes have been written in this stream
  int gen_written;
  bit gen_prior;  // whole window written by one stream (>= 8192 bytes)

  function automatic bit pop_flag();
    bit b;
    b = dec_flags[0];
    dec_flags = dec_flags >> 1;
    dec_left--;
    return b;
  endfunction

  function automatic void emit_byte(logic [7:0] v);
    dec_hist[dec_pos] = v;
    dec_pos = (dec_pos + 1) % WIN;
    run_bytes.push_back(v);
  endfunction

  function automatic void copy_back();
    for (int n = 0; n < dec_len; n++)
      emit_byte(dec_hist[(dec_pos + WIN - dec_dist) % WIN]);
  endfunction

  // Decode one compressed byte and queue the results it produces
  function automatic void decode_byte(item_t it);
    logic [7:0] b;
    logic [15:0] d;
    bit term;
    result_t r;
    int nres, cnt;
    b = it.in_byte;
    term = 0;
    run_bytes.delete();
    if (it.start_of_stream) begin
      dec_flags = '0; dec_left = 0; dec_low_held = 0; dec_phase = PH_TYPE; dec_pos = 0;
    end
    if (dec_phase == PH_DONE) return;
    if (dec_left == 0) begin
      if (!dec_low_held) begin
        dec_low = b; dec_low_held = 1;
      end else begin
        dec_flags = {b, dec_low}; dec_left = FLAG_BITS; dec_low_held = 0;
      end
    end else begin
      case (dec_phase)
        PH_LITERAL: begin
          emit_byte(b); dec_phase = PH_TYPE;
        end
        PH_INL_DIST: begin
          dec_dist = (b ^ 8'hFF) + 1; copy_back(); dec_phase = PH_TYPE;
        end
        PH_FULL_LO: begin
          dec_low = b; dec_phase = PH_FULL_HI;
        end
        PH_FULL_HI: begin
          d = 16'hE000 | ({8'h0, b & 8'hF8} << 5) | dec_low;
          dec_dist = ((d ^ 16'hFFFF) + 1) & 16'h3FFF;
          if (b[2:0] != 0) begin
            dec_len = b[2:0] + 2; copy_back(); dec_phase = PH_TYPE;
          end else dec_phase = PH_EXTEND;
        end
        PH_EXTEND: begin
          if (b == 0) begin
            term = 1; dec_phase = PH_DONE;
          end else if (b == 1) dec_phase = PH_TYPE;
          else begin
            dec_len = b + 1; copy_back(); dec_phase = PH_TYPE;
          end
        end
        default: ;
      endcase
    end
    // Consume flag bits while parsing waits on them
    while (dec_phase != PH_DONE && dec_left != 0) begin
      if (dec_phase == PH_TYPE) dec_phase = pop_flag() ? PH_LITERAL : PH_KIND;
      else if (dec_phase == PH_KIND) dec_phase = pop_flag() ? PH_FULL_LO : PH_INL_HI;
      else if (dec_phase == PH_INL_HI) begin
        dec_len = pop_flag() ? 4 : 2; dec_phase = PH_INL_LO;
      end else if (dec_phase == PH_INL_LO) begin
        dec_len += pop_flag(); dec_phase = PH_INL_DIST;
      end else break;
    end
    if (term) begin
      r = '0; r.last_of_run = 1; r.end_of_stream = 1;
      decoded_q.push_back(r);
      return;
    end
    nres = (run_bytes.size() + 3) / 4;
    for (int i = 0; i < nres; i++) begin
      cnt = run_bytes.size() - i * 4;
      if (cnt > 4) cnt = 4;
      r = '0;
      r.out_byte_a = run_bytes[i*4];
      if (cnt > 1) r.out_byte_b = run_bytes[i*4+1];
      if (cnt > 2) r.out_byte_c = run_bytes[i*4+2];
      if (cnt > 3) r.out_byte_d = run_bytes[i*4+3];
      r.valid_count = 3'(cnt);
      r.last_of_run = (i + 1 == nres);
      decoded_q.push_back(r);
    end
  endfunction

  function automatic void put_item(logic [7:0] b, bit sos);
    item_t it;
    it.in_byte = b; it.start_of_stream = sos;
    stim_q.push_back(it);
  endfunction

  // Distance limited so no read reaches unwritten history
  function automatic int max_dist();
    int m;
    m = gen_prior ? WIN : gen_written;
    return m;
  endfunction

  // Build one stream of tokens and push it, ending with terminator or not
  function automatic void build_stream(int ntok, bit terminate, bit directed);
    int kind, len, span, avail;
    bit first;
    logic [7:0] hb;
    logic [7:0] bytes_per [$][$];
    logic [7:0] cur [$];
    logic [7:0] carry [$];
    bit tb [$];
    bit tbits [$][$];
    gen_written = 0;
    // each token: flag bits + payload bytes
    for (int t = 0; t < ntok + terminate; t++) begin
      tb.delete(); cur.delete();
      avail = max_dist();
      if (t == ntok) kind = 5;
      else if (directed) kind = t % 6;
      else kind = $urandom_range(0, 5);
      if (avail < 2 && kind != 5) kind = 0;
      if (kind == 5 && !terminate && t == ntok) kind = 0;
      case (kind)
        0: begin
          tb.push_back(1); cur.push_back(8'($urandom_range(0, 255)));
          len = 1;
          if (directed && t < 2) cur[0] = t ? 8'hFF : 8'h00;
        end
        1: begin
          len = $urandom_range(2, 5);
          span = $urandom_range(1, avail > 256 ? 256 : avail);
          tb.push_back(0); tb.push_back(0);
          tb.push_back(len >= 4); tb.push_back(len[0]);
          cur.push_back(8'((256 - span) & 8'hFF));
        end
        2, 3: begin
          len = (kind == 2) ? $urandom_range(3, 9) : $urandom_range(3, 40);
          if ($urandom_range(0, 15) == 0) len = 256;
          span = $urandom_range(1, avail > 8191 ? 8191 : avail);
          if (directed && t == 3 && avail >= 8191) span = 8191;
          if (kind == 2 && len > 9) len = 9;
          tb.push_back(0); tb.push_back(1);
          span = 8192 - span;  // 13-bit encoded two's complement
          cur.push_back(span[7:0]);
          if (kind == 2) cur.push_back({span[12:8], 3'(len - 2)});
          else begin
            cur.push_back({span[12:8], 3'b000}); cur.push_back(8'(len - 1));
          end
        end
        4: begin
          tb.push_back(0); tb.push_back(1);
          hb = 8'($urandom_range(0, 255));
          cur.push_back(hb); cur.push_back({5'($urandom_range(0, 31)), 3'b000});
          cur.push_back(8'h01);
          len = 0;
        end
        default: begin
          tb.push_back(0); tb.push_back(1);
          cur.push_back(8'($urandom_range(0, 255)));
          cur.push_back({5'($urandom_range(0, 31)), 3'b000});
          cur.push_back(8'h00);
          len = 0;
        end
      endcase
      gen_written += len;
      if (gen_written >= WIN) gen_prior = 1;
      tbits.push_back(tb);
      bytes_per.push_back(cur);
    end
    // Serialize: flag word fetched when its bits run out, before payload
    first = 1;
    carry.delete();
    begin
      logic [15:0] fw;
      int ti;
      ti = 0;
      while (ti < tbits.size() || carry.size() != 0) begin
        // gather next 16 bits from tokens from ti onward
        int tj, bi, filled;
        logic [7:0] payload [$];
        fw = 16'($urandom_range(0, 65535));
        filled = 0;
        tj = ti; bi = 0;
        // payload of a token that used the last bit of the previous word
        payload = carry;
        carry.delete();
        // payload follows the bit that completes a token, or the next word
        // when that bit was the last one of this word
        while (filled < 16 && tj < tbits.size()) begin
          fw[filled] = tbits[tj][bi];
          filled++; bi++;
          if (bi == tbits[tj].size()) begin
            foreach (bytes_per[tj][k]) begin
              if (filled == 16) carry.push_back(bytes_per[tj][k]);
              else payload.push_back(bytes_per[tj][k]);
            end
            tj++; bi = 0;
          end
        end
        put_item(fw[7:0], first);
        put_item(fw[15:8], 0);
        first = 0;
        foreach (payload[k]) put_item(payload[k], 0);
        if (bi != 0) begin
          // token split across words: keep remaining bits
          tbits[tj] = tbits[tj][bi:$];
        end
        ti = tj;
      end
    end
  endfunction

  // Stimulus
  initial begin
    gen_prior = 0;
    dec_flags = '0; dec_left = 0; dec_low_held = 0; dec_phase = PH_TYPE;
    dec_low = '0; dec_len = 0; dec_dist = 0; dec_pos = 0;
    build_stream(12, 1, 1);
    put_item(8'hA5, 0);  // ignored after terminator
    put_item(8'h5A, 0);
    while (stim_q.size() < 100) build_stream($urandom_range(4, 14), $urandom_range(0, 3) != 0, 0);
    // one more stream without a terminator, then one with a terminator and trailing junk after it
    build_stream(6, 0, 0);
    build_stream(6, 1, 0);
    put_item(8'($urandom_range(0, 255)), 0);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver
  int phase_cnt = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        decode_byte(item);
        phase_cnt++;
      end
      if (!item_valid || !item_stall) begin
        if (item_valid && !item_stall && stim_q.size() == 0) item_valid <= 1'b0;
        else if ((!item_valid || !item_stall) && stim_q.size() != 0 &&
                 $urandom_range(0, 99) >= sender_idle_pct) begin
          item <= stim_q.pop_front();
          item_valid <= 1'b1;
        end else item_valid <= 1'b0;
      end
      result_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      if (phase_cnt < 45) begin
        sender_idle_pct <= 11; receiver_idle_pct <= 55;
      end else if (phase_cnt < 90) begin
        sender_idle_pct <= 55; receiver_idle_pct <= 11;
      end else begin
        sender_idle_pct <= 0; receiver_idle_pct <= 0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        exp_r = decoded_q.pop_front();
        if (result !== exp_r) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, result);
          errors++;
        end
      end
    end
  end

  // Watchdog and end of run
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) watchdog <= 0;
    else watchdog <= watchdog + 1;
  end

  initial begin
    wait (!rst);
    fork
      begin
        wait (stim_q.size() == 0 && !item_valid && decoded_q.size() == 0);
        repeat (700) @(posedge clk);
      end
      wait (watchdog >= WATCHDOG_LIMIT);
    join_any
    if (watchdog >= WATCHDOG_LIMIT || decoded_q.size() != 0 || errors != 0) begin
      $display("lzss_bitflag_decompressor regression: fail");
    end else begin
      $display("lzss_bitflag_decompressor regression: pass");
    end
    $finish;
  end

endmodule
